// ----- hdl/fsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format spec parser package
// Shared types, phase codes, character codes and helper functions for the
// conversion-specification parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // Parse phases.
    localparam logic [2:0] PH_FLAGS = 3'd0;
    localparam logic [2:0] PH_WIDTH = 3'd1;
    localparam logic [2:0] PH_PREC  = 3'd2;
    localparam logic [2:0] PH_LEN_H = 3'd3;
    localparam logic [2:0] PH_LEN_L = 3'd4;
    localparam logic [2:0] PH_CONV  = 3'd5;

    // Length modifier codes.
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_H    = 3'd1;
    localparam logic [2:0] LEN_HH   = 3'd2;
    localparam logic [2:0] LEN_L    = 3'd3;
    localparam logic [2:0] LEN_LL   = 3'd4;
    localparam logic [2:0] LEN_J    = 3'd5;
    localparam logic [2:0] LEN_Z    = 3'd6;

    // Character codes.
    localparam logic [7:0] C_PCT   = 8'h25;  // '%'
    localparam logic [7:0] C_HASH  = 8'h23;  // '#'
    localparam logic [7:0] C_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] C_NINE  = 8'h39;  // '9'
    localparam logic [7:0] C_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] C_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] C_SPACE = 8'h20;  // ' '
    localparam logic [7:0] C_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] C_LC_H  = 8'h68;  // 'h'
    localparam logic [7:0] C_LC_L  = 8'h6C;  // 'l'
    localparam logic [7:0] C_LC_J  = 8'h6A;  // 'j'
    localparam logic [7:0] C_LC_Z  = 8'h7A;  // 'z'

    localparam logic [15:0] ACC_MAX = 16'hFFFF;
    localparam logic [7:0]  CNT_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]  phase;
        logic [4:0]  flags_seen;
        logic [15:0] width_acc;
        logic [15:0] prec_acc;
        logic        prec_seen;
        logic [2:0]  length_mod;
        logic [7:0]  taken_count;
    } t_state;

    typedef struct packed {
        logic        done_res;
        logic        char_taken;
        logic        percent_literal;
        logic [7:0]  conversion;
        logic [4:0]  flag_bits;
        logic [15:0] field_width;
        logic [15:0] precision_value;
        logic        has_precision;
        logic [2:0]  length_code;
        logic [7:0]  consumed;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:       PH_FLAGS,
        flags_seen:  5'd0,
        width_acc:   16'd0,
        prec_acc:    16'd0,
        prec_seen:   1'b0,
        length_mod:  LEN_NONE,
        taken_count: 8'd0
    };

    // Flag mask: bit0 '#', bit1 '0', bit2 '-', bit3 '+', bit4 space.
    function automatic logic [4:0] flag_mask(input logic [7:0] ch);
        logic [4:0] m;
        case (ch)
            C_HASH:  m = 5'b00001;
            C_ZERO:  m = 5'b00010;
            C_MINUS: m = 5'b00100;
            C_PLUS:  m = 5'b01000;
            C_SPACE: m = 5'b10000;
            default: m = 5'b00000;
        endcase
        return m;
    endfunction

    // Conversion characters "sSpdDioOuUxXcC".
    function automatic logic is_conv(input logic [7:0] ch);
        return ch inside {8'h73, 8'h53, 8'h70, 8'h64, 8'h44, 8'h69, 8'h6F,
                          8'h4F, 8'h75, 8'h55, 8'h78, 8'h58, 8'h63, 8'h43};
    endfunction

    // acc * 10 + d, saturating at the 16-bit maximum.
    function automatic logic [15:0] acc_digit(input logic [15:0] acc,
                                              input logic [3:0]  d);
        logic [19:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, d};
        return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[15:0];
    endfunction

endpackage

// ----- hdl/format_spec_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format spec parser unit
// Parses a printf-style conversion specification one character per request.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready / i_ch) carries the characters
// that follow a percent sign, one per request. For every accepted character
// the output channel (o_out_valid / i_out_ready) delivers exactly one result
// request: whether the character ended the specification, whether it was
// part of it, and the flags, width, precision, length code and count
// accumulated so far. A result marked done closes the specification and the
// next character starts a new one.
// A character lands in the input register when it is accepted, and its result
// moves on into the output register as soon as that register is free.
// One character per cycle is taken while the receiver does not stall; the parse
// state is updated by a single decode and a 16-bit multiply-by-ten accumulate
// between the two registers, so consecutive characters follow without gaps.
// When the receiver stalls, the output register holds its result, the input
// register holds the next character, and o_in_ready drops once both are
// full. Reset (synchronous, active low) empties both registers and returns
// the parse state to the start of a specification.
// ----------------------------------------------------------------------------
module format_spec_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_done_res,
    output logic        o_char_taken,
    output logic        o_percent_literal,
    output logic [7:0]  o_conversion,
    output logic [4:0]  o_flag_bits,
    output logic [15:0] o_field_width,
    output logic [15:0] o_precision_value,
    output logic        o_has_precision,
    output logic [2:0]  o_length_code,
    output logic [7:0]  o_consumed
);

    // Input register stage.
    logic             r_in_valid;
    logic [7:0]       r_ch;
    // Parse state, advanced once per character that moves to the output.
    fsp_pkg::t_state  r_state;
    fsp_pkg::t_state  n_state;
    // Output register stage.
    logic             r_out_valid;
    fsp_pkg::t_result r_res;
    fsp_pkg::t_result n_res;

    logic advance;

    // The character in the input register moves on when the output register
    // is empty or is being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    fsp_step u_step (
        .i_state      (r_state),
        .i_ch         (r_ch),
        .o_next_state (n_state),
        .o_result     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsp_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_done_res        = r_res.done_res;
    assign o_char_taken      = r_res.char_taken;
    assign o_percent_literal = r_res.percent_literal;
    assign o_conversion      = r_res.conversion;
    assign o_flag_bits       = r_res.flag_bits;
    assign o_field_width     = r_res.field_width;
    assign o_precision_value = r_res.precision_value;
    assign o_has_precision   = r_res.has_precision;
    assign o_length_code     = r_res.length_code;
    assign o_consumed        = r_res.consumed;

    // A literal percent is always a one-character specification.
    a_pct_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.percent_literal |-> r_res.consumed == 8'd1)
        else $error("literal percent result with a count other than one");

    // Only a closing character can carry a conversion or be left untaken.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.conversion != 8'd0 || !r_res.char_taken)
        |-> r_res.done_res)
        else $error("conversion or untaken character without done");

    // After a closing result the state is back at the start.
    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_res.done_res |=> r_state == fsp_pkg::STATE_RESET)
        else $error("parse state not cleared after a finished specification");

    // A held character is not dropped while the output is stalled.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_ch))
        else $error("input register lost a character under stall");

    // An open specification has taken at least one character.
    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.done_res |-> r_res.consumed != 8'd0)
        else $error("open specification with a zero count");

endmodule

// ----- hdl/fsp_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Format spec parser step
// Combinational decode of one character against the current parse state:
// produces the next state and the result for that character.
// ----------------------------------------------------------------------------
module fsp_step (
    input  fsp_pkg::t_state  i_state,
    input  logic [7:0]       i_ch,
    output fsp_pkg::t_state  o_next_state,
    output fsp_pkg::t_result o_result
);

    fsp_pkg::t_state s;
    logic [4:0]      fmask;
    logic            digit;
    logic            done;
    logic            taken;
    logic            pct;
    logic [7:0]      conv;

    assign fmask = fsp_pkg::flag_mask(i_ch);
    assign digit = i_ch inside {[fsp_pkg::C_ZERO : fsp_pkg::C_NINE]};

    always_comb begin
        s     = i_state;
        done  = 1'b0;
        taken = 1'b1;
        pct   = 1'b0;
        conv  = 8'd0;

        if (i_state.taken_count == 8'd0 && i_ch == fsp_pkg::C_PCT) begin
            done = 1'b1;
            pct  = 1'b1;
        end else if (i_state.phase == fsp_pkg::PH_FLAGS && fmask != 5'd0) begin
            s.flags_seen = i_state.flags_seen | fmask;
        end else if (i_state.phase <= fsp_pkg::PH_WIDTH && digit) begin
            s.width_acc = fsp_pkg::acc_digit(i_state.width_acc, i_ch[3:0]);
            s.phase     = fsp_pkg::PH_WIDTH;
        end else if (i_state.phase <= fsp_pkg::PH_WIDTH && i_ch == fsp_pkg::C_DOT) begin
            s.phase = fsp_pkg::PH_PREC;
        end else if (i_state.phase == fsp_pkg::PH_PREC && digit) begin
            s.prec_acc  = fsp_pkg::acc_digit(i_state.prec_acc, i_ch[3:0]);
            s.prec_seen = 1'b1;
        end else if (i_state.phase <= fsp_pkg::PH_PREC && i_ch == fsp_pkg::C_LC_H) begin
            s.length_mod = fsp_pkg::LEN_H;
            s.phase      = fsp_pkg::PH_LEN_H;
        end else if (i_state.phase <= fsp_pkg::PH_PREC && i_ch == fsp_pkg::C_LC_L) begin
            s.length_mod = fsp_pkg::LEN_L;
            s.phase      = fsp_pkg::PH_LEN_L;
        end else if (i_state.phase <= fsp_pkg::PH_PREC && i_ch == fsp_pkg::C_LC_J) begin
            s.length_mod = fsp_pkg::LEN_J;
            s.phase      = fsp_pkg::PH_CONV;
        end else if (i_state.phase <= fsp_pkg::PH_PREC && i_ch == fsp_pkg::C_LC_Z) begin
            s.length_mod = fsp_pkg::LEN_Z;
            s.phase      = fsp_pkg::PH_CONV;
        end else if (i_state.phase == fsp_pkg::PH_LEN_H && i_ch == fsp_pkg::C_LC_H) begin
            s.length_mod = fsp_pkg::LEN_HH;
            s.phase      = fsp_pkg::PH_CONV;
        end else if (i_state.phase == fsp_pkg::PH_LEN_L && i_ch == fsp_pkg::C_LC_L) begin
            s.length_mod = fsp_pkg::LEN_LL;
            s.phase      = fsp_pkg::PH_CONV;
        end else if (fsp_pkg::is_conv(i_ch)) begin
            done = 1'b1;
            conv = i_ch;
        end else begin
            done  = 1'b1;
            taken = 1'b0;
        end

        if (taken && i_state.taken_count != fsp_pkg::CNT_MAX) begin
            s.taken_count = i_state.taken_count + 8'd1;
        end

        o_result.done_res        = done;
        o_result.char_taken      = taken;
        o_result.percent_literal = pct;
        o_result.conversion      = conv;
        o_result.flag_bits       = s.flags_seen;
        o_result.field_width     = s.width_acc;
        o_result.precision_value = s.prec_acc;
        o_result.has_precision   = s.prec_seen;
        o_result.length_code     = s.length_mod;
        o_result.consumed        = s.taken_count;

        // A finished specification starts the next one from scratch.
        o_next_state = done ? fsp_pkg::STATE_RESET : s;
    end

endmodule
